### hdl/bms_pkg.sv
// bms_pkg: shared types, constants and the radix-16 divide-by-five digit step
// for the block mean and spread engine; depends on nothing
package bms_pkg;

	// samples per group, minus one (last value of the group position counter)
	localparam logic [2:0] GROUP_LAST = 3'd4;

	// dividend bits retired per cycle by the divide-by-five unit
	localparam int DIGIT_BITS = 4;

	localparam logic [3:0] DIVISOR = 4'd5;

	typedef struct packed {
		logic [2:0] rem;
		logic [3:0] quo;
	} div5_res_t;

	// four restoring steps of a divide by five on a narrow remainder
	function automatic div5_res_t div5_digit(input logic [2:0] rem_in, input logic [3:0] digit);
		div5_res_t res;
		logic [3:0] r;
		res.rem = rem_in;
		res.quo = '0;
		for (int i = 3; i >= 0; i--) begin
			r = {res.rem, digit[i]};
			if (r >= DIVISOR) begin
				r = r - DIVISOR;
				res.quo[i] = 1'b1;
			end
			res.rem = r[2:0];
		end
		return res;
	endfunction

endpackage

### hdl/bms_if.sv
// bms_if: valid/ready channels for sample items and result items
// standalone, no package needed
interface bms_sample_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] voltage_code;
	logic signed [SAMPLE_BITS-1:0] current_code;

	modport source(output valid, output voltage_code, output current_code, input ready);
	modport sink(input valid, input voltage_code, input current_code, output ready);
endinterface

interface bms_result_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] mean_voltage;
	logic signed [SAMPLE_BITS-1:0] mean_current;
	logic        [SAMPLE_BITS-1:0] current_spread;

	modport source(output valid, output mean_voltage, output mean_current,
		output current_spread, input ready);
	modport sink(input valid, input mean_voltage, input mean_current,
		input current_spread, output ready);
endinterface

### hdl/block_mean_and_spread.sv
// block_mean_and_spread: means and sample standard deviation over groups of five items
// depends on bms_pkg and the channel interfaces in bms_if.sv
// items 1..4 of a group: capture, square on the shared multiplier, accumulate
// item 5: capture, square and accumulate, then the result is computed by the radix-16
//   divide-by-five unit (three divisions) and the bit-serial square root
// one item in flight at a time; a pending result does not block the next four items
// arst_n clears the fsm, group position, sums and result valid; payload registers are not reset
module block_mean_and_spread
	import bms_pkg::*;
#(
	parameter int SAMPLE_BITS = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	bms_sample_if.sink    samples,
	bms_result_if.source  results
);

	localparam int W    = SAMPLE_BITS;
	localparam int SW   = W + 3;                  // running sums of five samples
	localparam int QW   = 2 * W + 1;              // sum of five squares
	localparam int MW   = W + 2;                  // magnitude of a sum
	localparam int PW   = 2 * MW;                 // multiplier product, also 5*Q
	localparam int VW   = PW + 1;                 // 5*Q - S*S with sign
	localparam int DDW  = 2 * W + 2;              // (5*Q - S*S) / 4
	localparam int DW   = ((DDW + DIGIT_BITS - 1) / DIGIT_BITS) * DIGIT_BITS;
	localparam int DIGS = DW / DIGIT_BITS;
	localparam int CW   = $clog2(W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQR,
		ST_ACC,
		ST_SSQ,
		ST_DIV_V,
		ST_DIV_C,
		ST_DIV_D,
		ST_SQRT
	} state_t;

	// control state
	state_t                 state_q;
	logic [2:0]             pos_q;
	logic [CW-1:0]          cnt_q;
	logic                   out_valid_q;
	logic signed [SW-1:0]   vsum_q;
	logic signed [SW-1:0]   csum_q;
	logic [QW-1:0]          qsum_q;

	// datapath registers
	logic signed [W-1:0]    volt_q;
	logic signed [W-1:0]    curr_q;
	logic [PW-1:0]          prod_q;
	logic [PW-1:0]          fiveq_q;
	logic [DW-1:0]          div_q;
	logic [2:0]             drem_q;
	logic [2*W-1:0]         sop_q;
	logic [W-1:0]           srem_q;
	logic [W-1:0]           root_q;
	logic signed [W-1:0]    mean_v_q;
	logic signed [W-1:0]    mean_c_q;

	// combinational
	logic [W-1:0]           curr_mag;
	logic [SW-1:0]          vsum_neg;
	logic [SW-1:0]          csum_neg;
	logic [MW-1:0]          vsum_mag;
	logic [MW-1:0]          csum_mag;
	logic [MW-1:0]          mul_op;
	logic [PW-1:0]          mul_res;
	logic [VW-1:0]          var_diff;
	logic                   var_neg;
	logic [DDW-1:0]         var_dvd;
	div5_res_t              dstep;
	logic [DW-1:0]          div_nxt;
	logic [MW-1:0]          quo_mag;
	logic [MW-1:0]          quo_neg;
	logic                   mean_neg;
	logic [W-1:0]           mean_nxt;
	logic [W+1:0]           srem_sh;
	logic [W+1:0]           trial;
	logic                   sq_ge;
	logic [W+1:0]           srem_nxt;
	logic [W-1:0]           root_nxt;
	logic                   div_last;
	logic                   sqrt_last;
	logic                   acc_hold;
	logic                   accept;

	assign accept = samples.valid && samples.ready;

	// magnitudes for the shared squarer and the divider
	assign curr_mag = curr_q[W-1] ? W'(-curr_q) : W'(curr_q);
	assign vsum_neg = -vsum_q;
	assign csum_neg = -csum_q;
	assign vsum_mag = vsum_q[SW-1] ? vsum_neg[MW-1:0] : vsum_q[MW-1:0];
	assign csum_mag = csum_q[SW-1] ? csum_neg[MW-1:0] : csum_q[MW-1:0];

	// one multiplier: squares the current sample per item, then the current sum per group
	assign mul_op  = (state_q == ST_SQR) ? MW'(curr_mag) : csum_mag;
	assign mul_res = mul_op * mul_op;

	// 5*Q - S*S, never negative in exact arithmetic; the /4 part of /20 is a shift
	assign var_diff = {1'b0, fiveq_q} - {1'b0, prod_q};
	assign var_neg  = var_diff[VW-1];
	assign var_dvd  = var_neg ? '0 : var_diff[DDW+1:2];

	// divide-by-five: one hex digit in, one quotient digit shifted into the low end
	assign dstep   = div5_digit(drem_q, div_q[DW-1 -: DIGIT_BITS]);
	assign div_nxt = {div_q[DW-DIGIT_BITS-1:0], dstep.quo};

	// signed mean from the quotient magnitude, truncation toward zero
	assign quo_mag  = div_nxt[MW-1:0];
	assign quo_neg  = -quo_mag;
	assign mean_neg = (state_q == ST_DIV_V) ? vsum_q[SW-1] : csum_q[SW-1];
	assign mean_nxt = mean_neg ? quo_neg[W-1:0] : quo_mag[W-1:0];

	// bit-serial square root, one result bit per cycle
	assign srem_sh  = {srem_q, sop_q[2*W-1 -: 2]};
	assign trial    = {root_q, 2'b01};
	assign sq_ge    = srem_sh >= trial;
	assign srem_nxt = sq_ge ? (srem_sh - trial) : srem_sh;
	assign root_nxt = {root_q[W-2:0], sq_ge};

	assign div_last  = cnt_q == CW'(DIGS - 1);
	assign sqrt_last = cnt_q == CW'(W - 1);

	// fifth item waits here while the previous result is still pending
	assign acc_hold = (pos_q == GROUP_LAST) && out_valid_q;

	assign samples.ready          = state_q == ST_IDLE;
	assign results.valid          = out_valid_q;
	assign results.mean_voltage   = mean_v_q;
	assign results.mean_current   = mean_c_q;
	assign results.current_spread = root_q;

	// sequencer, group state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			vsum_q      <= '0;
			csum_q      <= '0;
			qsum_q      <= '0;
		end else begin
			if (results.ready && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (samples.valid) begin
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (!acc_hold) begin
						vsum_q <= vsum_q + SW'(volt_q);
						csum_q <= csum_q + SW'(curr_q);
						qsum_q <= qsum_q + prod_q[QW-1:0];
						if (pos_q == GROUP_LAST) begin
							state_q <= ST_SSQ;
						end else begin
							pos_q   <= pos_q + 3'd1;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_SSQ: begin
					cnt_q   <= '0;
					state_q <= ST_DIV_V;
				end
				ST_DIV_V: begin
					if (div_last) begin
						cnt_q   <= '0;
						state_q <= ST_DIV_C;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV_C: begin
					if (div_last) begin
						cnt_q   <= '0;
						state_q <= ST_DIV_D;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV_D: begin
					if (div_last) begin
						cnt_q   <= '0;
						state_q <= ST_SQRT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SQRT: begin
					if (sqrt_last) begin
						out_valid_q <= 1'b1;
						pos_q       <= '0;
						vsum_q      <= '0;
						csum_q      <= '0;
						qsum_q      <= '0;
						cnt_q       <= '0;
						state_q     <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
			endcase
		end
	end

	// datapath: operand capture, shared squarer, divider and square root registers
	always_ff @(posedge clk) begin
		if (accept) begin
			volt_q <= samples.voltage_code;
			curr_q <= samples.current_code;
		end
		unique case (state_q)
			ST_SQR: begin
				prod_q <= mul_res;
			end
			ST_SSQ: begin
				prod_q  <= mul_res;
				fiveq_q <= (PW'(qsum_q) << 2) + PW'(qsum_q);
				div_q   <= DW'(vsum_mag);
				drem_q  <= '0;
			end
			ST_DIV_V: begin
				if (div_last) begin
					mean_v_q <= mean_nxt;
					div_q    <= DW'(csum_mag);
					drem_q   <= '0;
				end else begin
					div_q  <= div_nxt;
					drem_q <= dstep.rem;
				end
			end
			ST_DIV_C: begin
				if (div_last) begin
					mean_c_q <= mean_nxt;
					div_q    <= DW'(var_dvd);
					drem_q   <= '0;
				end else begin
					div_q  <= div_nxt;
					drem_q <= dstep.rem;
				end
			end
			ST_DIV_D: begin
				if (div_last) begin
					sop_q  <= div_nxt[2*W-1:0];
					srem_q <= '0;
					root_q <= '0;
				end else begin
					div_q  <= div_nxt;
					drem_q <= dstep.rem;
				end
			end
			ST_SQRT: begin
				sop_q  <= sop_q << 2;
				srem_q <= srem_nxt[W-1:0];
				root_q <= root_nxt;
			end
			default: begin
			end
		endcase
	end

	// group position never passes the fifth item
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= GROUP_LAST)
		else $error("group position out of range");

	// an accepted item always starts the squaring step
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_SQR)
		else $error("accepted item did not start");

	// a new result leaves the group state cleared
	a_result_clears: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (pos_q == 3'd0 && vsum_q == '0 && csum_q == '0 && qsum_q == '0))
		else $error("sums not cleared with result");

	// 5*Q is never below S*S
	a_var_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_C && div_last) |-> !var_neg)
		else $error("negative variance numerator");

	// fifth item does not overrun a pending result
	a_hold_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC && acc_hold && !results.ready) |=> state_q == ST_ACC)
		else $error("group finished over a pending result");

endmodule
